### rtl/cmf_pkg.sv
// closable mailbox fifo: shared types and constants
// field widths, command and status codes, controller command struct
// no dependencies
`default_nettype none

package cmf_pkg;

    // fixed field widths
    localparam int CMD_W    = 2;
    localparam int MSG_W    = 64;
    localparam int STATUS_W = 3;
    localparam int CNT_W    = 5;   // capacity register and occupancy
    localparam int TOT_W    = 32;

    // packed word widths, padded to whole bytes
    localparam int IN_W  = 72;
    localparam int OUT_W = 176;

    // command codes
    localparam logic [CMD_W-1:0] CMD_SEND  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RECV  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLOSE = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CLOSED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ALREADY = 3'd4;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;  // latch the incoming word
        logic commit;   // execute the latched command and load the result
    } cmf_ctrl_t;

endpackage

`default_nettype wire

### rtl/cmf_ram.sv
// generic single write port, single read port ram with registered read
// used for the mailbox slot store
// no dependencies
`default_nettype none

module cmf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### rtl/cmf_ctrl.sv
// closable mailbox fifo controller: input handshake, sequencing, output valid
// depends on cmf_pkg
`default_nettype none

module cmf_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output cmf_pkg::cmf_ctrl_t     ctrl
);
    import cmf_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign out_free = !out_valid_reg || m_tready;

    // sequencing: take a word, then execute once the slot read is back
    // and the output register is free
    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        ctrl.capture   = 1'b0;
        ctrl.commit    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    ctrl.capture = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    ctrl.commit    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### rtl/cmf_dpath.sv
// closable mailbox fifo datapath: capacity register, ring pointers, counters,
// slot store and result register
// depends on cmf_pkg and cmf_ram
`default_nettype none

module cmf_dpath #(
    parameter int DEPTH     = 16,
    parameter int MSG_BYTES = 8
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire cmf_pkg::cmf_ctrl_t          ctrl,
    input  wire logic [cmf_pkg::IN_W-1:0]    s_tdata,
    output logic      [cmf_pkg::OUT_W-1:0]   m_tdata,
    input  wire logic                        cfg_wr_en,
    input  wire logic [cmf_pkg::CNT_W-1:0]   cfg_wr_data
);
    import cmf_pkg::*;

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int SLOT_W = MSG_BYTES * 8;
    // largest capacity the 5-bit register can select on this depth
    localparam logic [CNT_W-1:0] CAP_MAX =
        (DEPTH > 31) ? CNT_W'(31) : CNT_W'(DEPTH);

    // latched input word
    logic [CMD_W-1:0]  cmd_reg;
    logic [SLOT_W-1:0] msg_reg;

    // mailbox state
    logic [CNT_W-1:0] cap_reg;
    logic [PTR_W-1:0] rpos_reg, rpos_next;
    logic [PTR_W-1:0] wpos_reg, wpos_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             closed_reg, closed_next;
    logic [TOT_W-1:0] sent_reg, sent_next;
    logic [TOT_W-1:0] recv_reg, recv_next;
    logic [TOT_W-1:0] drop_reg, drop_next;

    // result
    logic [STATUS_W-1:0] status_next;
    logic [MSG_W-1:0]    rx_next;
    logic [OUT_W-1:0]    result_reg;

    logic [CNT_W-1:0]  cap_eff;
    logic [CNT_W-1:0]  rpos_inc, wpos_inc;
    logic              ram_wr_en;
    logic [SLOT_W-1:0] ram_rd_data;

    // capture the incoming word, message trimmed to the slot width
    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            cmd_reg <= s_tdata[CMD_W-1:0];
            msg_reg <= s_tdata[CMD_W +: SLOT_W];
        end
    end

    // capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CNT_W'(16);
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    // effective capacity: zero acts as one, clamp to the ring depth
    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = CNT_W'(1);
        end else if (cap_reg > CAP_MAX) begin
            cap_eff = CAP_MAX;
        end else begin
            cap_eff = cap_reg;
        end
    end

    // pointer increments, wrapping at the capacity
    assign rpos_inc = CNT_W'(rpos_reg) + CNT_W'(1);
    assign wpos_inc = CNT_W'(wpos_reg) + CNT_W'(1);

    // slot store, read address follows the read pointer
    cmf_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (wpos_reg),
        .wr_data (msg_reg),
        .rd_addr (rpos_reg),
        .rd_data (ram_rd_data)
    );

    // command execution
    always_comb begin
        rpos_next   = rpos_reg;
        wpos_next   = wpos_reg;
        count_next  = count_reg;
        closed_next = closed_reg;
        sent_next   = sent_reg;
        recv_next   = recv_reg;
        drop_next   = drop_reg;
        status_next = ST_OK;
        rx_next     = '0;
        ram_wr_en   = 1'b0;
        unique case (cmd_reg)
            CMD_SEND: begin
                if (closed_reg) begin
                    status_next = ST_CLOSED;
                end else if (count_reg >= cap_eff) begin
                    status_next = ST_FULL;
                    drop_next   = drop_reg + TOT_W'(1);
                end else begin
                    ram_wr_en  = ctrl.commit;
                    wpos_next  = (wpos_inc >= cap_eff) ? '0 : PTR_W'(wpos_inc);
                    count_next = count_reg + CNT_W'(1);
                    sent_next  = sent_reg + TOT_W'(1);
                end
            end
            CMD_RECV: begin
                if (count_reg == '0) begin
                    status_next = ST_EMPTY;
                end else begin
                    rx_next    = MSG_W'(ram_rd_data);
                    rpos_next  = (rpos_inc >= cap_eff) ? '0 : PTR_W'(rpos_inc);
                    count_next = count_reg - CNT_W'(1);
                    recv_next  = recv_reg + TOT_W'(1);
                end
            end
            CMD_CLOSE: begin
                if (closed_reg) begin
                    status_next = ST_ALREADY;
                end else begin
                    closed_next = 1'b1;
                end
            end
            default: ;  // unknown command leaves everything as is
        endcase
    end

    // mailbox state update on commit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rpos_reg   <= '0;
            wpos_reg   <= '0;
            count_reg  <= '0;
            closed_reg <= 1'b0;
            sent_reg   <= '0;
            recv_reg   <= '0;
            drop_reg   <= '0;
        end else if (ctrl.commit) begin
            rpos_reg   <= rpos_next;
            wpos_reg   <= wpos_next;
            count_reg  <= count_next;
            closed_reg <= closed_next;
            sent_reg   <= sent_next;
            recv_reg   <= recv_next;
            drop_reg   <= drop_next;
        end
    end

    // result word register
    always_ff @(posedge aclk) begin
        if (ctrl.commit) begin
            result_reg <= {7'b0, drop_next, recv_next, sent_next, closed_next,
                           count_next, rx_next, status_next};
        end
    end

    assign m_tdata = result_reg;

endmodule

`default_nettype wire

### rtl/closable_mailbox_fifo_top.sv
// closable mailbox fifo: top level
// Commands arrive as words on the s_ stream: send stores a message in a ring
// of DEPTH slots, receive returns the oldest one, close latches the mailbox
// shut (receives still drain it). Each command yields exactly one result word
// on the m_ stream with status, received message, occupancy, closed flag and
// three wrapping 32-bit totals (sent, received, dropped because full).
// cfg_wr_en/cfg_wr_data set the number of ring slots in use (0 acts as 1,
// values above DEPTH act as DEPTH); write it only while no command is pending.
// An accepted word is latched in the input registers; its command then executes
// and its result is loaded into the output register once that register is free.
// No new command is taken until the last one completes; the slot store has
// a registered read port, so each command waits in EXEC for the slot read.
// When the receiver stalls, the result is held in the output register and
// the next command is still taken; it completes as soon as that result
// leaves. Reset (aresetn low, synchronous) empties and reopens the mailbox,
// clears the totals and sets the capacity to 16 slots; slot contents are
// not cleared and need no clearing pass.
// depends on cmf_pkg, cmf_ctrl, cmf_dpath, cmf_ram
`default_nettype none

module closable_mailbox_fifo_top #(
    parameter int DEPTH     = 16,
    parameter int MSG_BYTES = 8
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // command stream
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // [1:0] command, [65:2] message_in, [71:66] zero
    input  wire logic [cmf_pkg::IN_W-1:0]   s_tdata,
    // result stream
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // [2:0] status, [66:3] message_out, [71:67] occupancy, [72] closed_flag,
    // [104:73] sent_total, [136:105] received_total,
    // [168:137] dropped_total, [175:169] zero
    output logic      [cmf_pkg::OUT_W-1:0]  m_tdata,
    // capacity register write
    input  wire logic                       cfg_wr_en,
    input  wire logic [cmf_pkg::CNT_W-1:0]  cfg_wr_data
);
    import cmf_pkg::*;

    cmf_ctrl_t ctrl;

    cmf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctrl     (ctrl)
    );

    cmf_dpath #(
        .DEPTH     (DEPTH),
        .MSG_BYTES (MSG_BYTES)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .s_tdata     (s_tdata),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // a taken word blocks further input until its result is produced
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("command accepted while another is pending");

    // a new result only appears on the cycle a pending command completes
    a_result_from_command: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !$past(m_tvalid)) |-> ($past(!s_tready) && s_tready))
        else $error("result produced without a pending command");

    // occupancy never exceeds the ring depth
    a_occupancy_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (32'(m_tdata[71:67]) <= DEPTH))
        else $error("occupancy above ring depth");

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// testbench for closable_mailbox_fifo_top: streamed send, receive, close and unknown words
// checked against an in-bench mailbox predictor, with random idling on both sides
// depends on cmf_pkg and closable_mailbox_fifo_top

module testbench;
    import cmf_pkg::*;

    localparam int DEPTH       = 16;
    localparam int MSG_BYTES   = 8;
    localparam int CYCLE_LIMIT = 500000;
    localparam int REPORT_MAX  = 10;

    // command value the block must treat as a no-op
    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

    localparam logic [MSG_W-1:0] MSG_MASK =
        (MSG_BYTES >= 8) ? {MSG_W{1'b1}} : ((64'd1 << (MSG_BYTES * 8)) - 64'd1);

    // one command word, message above command as on s_tdata
    typedef struct packed {
        logic [MSG_W-1:0] message;
        logic [CMD_W-1:0] command;
    } command_word_t;

    // one result word, fields from the top bit down as on m_tdata
    typedef struct packed {
        logic [TOT_W-1:0]    dropped;
        logic [TOT_W-1:0]    received;
        logic [TOT_W-1:0]    sent;
        logic                closed;
        logic [CNT_W-1:0]    occupancy;
        logic [MSG_W-1:0]    message;
        logic [STATUS_W-1:0] status;
    } result_word_t;

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               s_tvalid    = 1'b0;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata     = '0;
    logic               m_tvalid;
    logic               m_tready    = 1'b0;
    logic [OUT_W-1:0]   m_tdata;
    logic               cfg_wr_en   = 1'b0;
    logic [CNT_W-1:0]   cfg_wr_data = '0;

    closable_mailbox_fifo_top #(
        .DEPTH     (DEPTH),
        .MSG_BYTES (MSG_BYTES)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    // stimulus and result bookkeeping
    command_word_t command_backlog[$];
    result_word_t  results_due[$];
    int            fail_count    = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            hold_requests = 0;
    int            hold_served;
    int            hold_left;
    int            send_gap;
    int            recv_gap;
    int            cycle_count   = 0;

    // predicted mailbox state
    logic [MSG_W-1:0] mb_slots [DEPTH];
    int               mb_rd_pos;
    int               mb_wr_pos;
    int               mb_count;
    logic             mb_closed;
    logic [TOT_W-1:0] mb_sent;
    logic [TOT_W-1:0] mb_received;
    logic [TOT_W-1:0] mb_dropped;
    logic [CNT_W-1:0] mb_capacity;

    // apply one command to the predicted mailbox and return its result word
    function automatic result_word_t mailbox_step(input logic [CMD_W-1:0] cmd,
                                                  input logic [MSG_W-1:0] msg);
        result_word_t r;
        int           cap;
        r        = '0;
        r.status = ST_OK;
        cap = (mb_capacity == 0) ? 1 : ((mb_capacity > DEPTH) ? DEPTH : int'(mb_capacity));
        case (cmd)
            CMD_SEND: begin
                if (mb_closed) begin
                    r.status = ST_CLOSED;
                end else if (mb_count >= cap) begin
                    r.status   = ST_FULL;
                    mb_dropped = mb_dropped + 1;
                end else begin
                    mb_slots[mb_wr_pos % DEPTH] = msg & MSG_MASK;
                    mb_wr_pos = (mb_wr_pos + 1 >= cap) ? 0 : mb_wr_pos + 1;
                    mb_count  = mb_count + 1;
                    mb_sent   = mb_sent + 1;
                end
            end
            CMD_RECV: begin
                if (mb_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.message   = mb_slots[mb_rd_pos % DEPTH];
                    mb_rd_pos   = (mb_rd_pos + 1 >= cap) ? 0 : mb_rd_pos + 1;
                    mb_count    = mb_count - 1;
                    mb_received = mb_received + 1;
                end
            end
            CMD_CLOSE: begin
                if (mb_closed) r.status = ST_ALREADY;
                else mb_closed = 1'b1;
            end
            default: ;
        endcase
        r.occupancy = mb_count[CNT_W-1:0];
        r.closed    = mb_closed;
        r.sent      = mb_sent;
        r.received  = mb_received;
        r.dropped   = mb_dropped;
        return r;
    endfunction

    task automatic note_failure(input string what, input logic [MSG_W-1:0] want,
                                input logic [MSG_W-1:0] got);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("%0t: %s mismatch: expected %0h, actual %0h", $realtime, what, want, got);
    endtask

    task automatic check_field(input string what, input logic [MSG_W-1:0] want,
                               input logic [MSG_W-1:0] got);
        if (want !== got) note_failure(what, want, got);
    endtask

    // driver: offers backlog words, predicts each accepted word
    always @(posedge aclk) begin : command_driver
        command_word_t next_word;
        if (!aresetn) begin
            s_tvalid    <= 1'b0;
            s_tdata     <= '0;
            send_gap    <= 0;
            mb_rd_pos   = 0;
            mb_wr_pos   = 0;
            mb_count    = 0;
            mb_closed   = 1'b0;
            mb_sent     = '0;
            mb_received = '0;
            mb_dropped  = '0;
            mb_capacity = 5'd16;
            foreach (mb_slots[i]) mb_slots[i] = '0;
        end else begin
            if (cfg_wr_en) mb_capacity = cfg_wr_data;
            if (s_tvalid && s_tready)
                results_due.push_back(mailbox_step(s_tdata[CMD_W-1:0],
                                                   s_tdata[CMD_W +: MSG_W]));
            // channel free for a new word unless one is still waiting
            if (!s_tvalid || s_tready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (command_backlog.size() != 0 && send_idle_pct != 0 &&
                             $urandom_range(0, 99) < send_idle_pct) begin
                    send_gap <= $urandom_range(0, 15);
                    s_tvalid <= 1'b0;
                end else if (command_backlog.size() != 0) begin
                    next_word = command_backlog.pop_front();
                    s_tvalid  <= 1'b1;
                    s_tdata   <= {{(IN_W - CMD_W - MSG_W){1'b0}}, next_word};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left   <= 0;
            hold_served <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_served < hold_requests) begin
            hold_left   <= $urandom_range(60, 120);
            hold_served <= hold_served + 1;
        end
    end

    // monitor: checks each accepted result word, paces m_tready
    always @(posedge aclk) begin : result_monitor
        result_word_t want;
        result_word_t got;
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(result_word_t)-1:0];
                if (results_due.size() == 0) begin
                    note_failure("unexpected result word status", '0, got.status);
                end else begin
                    want = results_due.pop_front();
                    check_field("status",         want.status,    got.status);
                    check_field("message_out",    want.message,   got.message);
                    check_field("occupancy",      want.occupancy, got.occupancy);
                    check_field("closed_flag",    want.closed,    got.closed);
                    check_field("sent_total",     want.sent,      got.sent);
                    check_field("received_total", want.received,  got.received);
                    check_field("dropped_total",  want.dropped,   got.dropped);
                end
            end
            if (hold_left != 0) begin
                m_tready <= 1'b0;
            end else if (recv_gap != 0) begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
                recv_gap <= $urandom_range(0, 15);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("closable_mailbox_fifo_top test failed");
            $finish;
        end
    end

    function automatic logic [MSG_W-1:0] random_message();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 64'd1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // call at a falling edge
    task automatic queue_word(input logic [CMD_W-1:0] cmd, input logic [MSG_W-1:0] msg);
        command_word_t w;
        w.command = cmd;
        w.message = msg;
        command_backlog.push_back(w);
    endtask

    // sender waits until every word is out and every result is back
    task automatic wait_drained();
        @(negedge aclk);
        while (command_backlog.size() != 0 || s_tvalid || results_due.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_capacity(input logic [CNT_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // one random phase at a given capacity and send bias
    task automatic run_phase(input logic [CNT_W-1:0] cap, input int count, input int send_pct,
                             input int tx_idle, input int rx_idle, input bit long_hold);
        logic [CMD_W-1:0] cmd;
        wait_drained();
        write_capacity(cap);
        @(negedge aclk);
        send_idle_pct = tx_idle;
        recv_idle_pct = rx_idle;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < 3) cmd = CMD_UNKNOWN;
            else if ($urandom_range(0, 99) < send_pct) cmd = CMD_SEND;
            else cmd = CMD_RECV;
            queue_word(cmd, random_message());
        end
        if (long_hold) hold_requests = hold_requests + 1;
    endtask

    initial begin
        logic [CMD_W-1:0] cmd;
        int               r;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty receive, no-op command, fill every slot, overflow, drain two
        @(negedge aclk);
        send_idle_pct = 10;
        recv_idle_pct = 10;
        queue_word(CMD_RECV, '1);
        queue_word(CMD_UNKNOWN, '1);
        queue_word(CMD_SEND, '0);
        queue_word(CMD_SEND, '1);
        for (int k = 0; k < 14; k++) queue_word(CMD_SEND, random_message());
        queue_word(CMD_SEND, 64'hA5A5_5A5A_0F0F_F0F0);
        queue_word(CMD_RECV, '0);
        queue_word(CMD_RECV, '0);

        // random phases; every slot is written by now, so capacity may change in use
        run_phase(5'd1,  120, 50, 10, 10, 1'b0);
        run_phase(5'd0,  100, 60, 0,  0,  1'b0);
        run_phase(5'd2,  120, 50, 20, 20, 1'b0);
        run_phase(5'd31, 150, 70, 5,  5,  1'b1);
        run_phase(5'd16, 150, 30, 10, 25, 1'b0);
        run_phase(5'd5,  150, 55, 25, 10, 1'b0);
        run_phase(5'd17, 100, 50, 0,  0,  1'b0);
        run_phase(5'd3,  100, 45, 15, 15, 1'b1);
        run_phase(5'($urandom_range(1, 16)), 150, 50, 10, 10, 1'b0);
        run_phase(5'd8,  100, 50, 10, 10, 1'b0);
        run_phase(5'd16, 100, 65, 0,  0,  1'b0);

        // close the mailbox, then keep sending, closing and draining
        wait_drained();
        queue_word(CMD_CLOSE, random_message());
        queue_word(CMD_CLOSE, random_message());
        queue_word(CMD_SEND, random_message());
        for (int k = 0; k < 90; k++) begin
            r = $urandom_range(0, 99);
            if (r < 10) cmd = CMD_CLOSE;
            else if (r < 15) cmd = CMD_UNKNOWN;
            else if (r < 45) cmd = CMD_SEND;
            else cmd = CMD_RECV;
            queue_word(cmd, random_message());
        end

        wait_drained();
        repeat (10) @(negedge aclk);
        if (fail_count == 0) begin
            $display("closable_mailbox_fifo_top test passed");
        end else begin
            $display("closable_mailbox_fifo_top test failed");
        end
        $finish;
    end

endmodule
